// File: sv/sgkd_pkg.sv
// Package with the shared constants and codes of the gravity kick/drift core.
`default_nettype none
package sgkd_pkg;
    localparam int WORD_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int GRAV_FRAC  = 24;

    typedef enum logic [1:0] {
        OP_KICK_3D = 2'd0,
        OP_KICK_2D = 2'd1,
        OP_DRIFT   = 2'd2,
        OP_PASS    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_SKIP = 2'd1,
        ST_SAT  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CFG_SOFTENING = 2'd0,
        CFG_GRAVITY   = 2'd1,
        CFG_FPS       = 2'd2
    } t_cfg_idx;
endpackage
`default_nettype wire

// File: sv/sgkd_if.sv
// Valid/ready channel interface carrying one item of payload type T.
`default_nettype none
interface sgkd_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: sv/sgkd_div.sv
// Pipelined restoring divider: one quotient bit per stage, stall-aware.
`default_nettype none
module sgkd_div #(
    parameter int NW = 96,
    parameter int DW = 96,
    parameter int QW = 33,
    parameter int TW = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    input  wire logic [TW-1:0] i_tag,
    output logic               o_valid,
    output logic [QW-1:0]      o_quo,
    output logic [TW-1:0]      o_tag
);
    // Quotients above 2^(QW-1) saturate to 2^(QW-1).
    localparam logic [QW-1:0] QMAX = QW'(1) << (QW - 1);

    logic [NW-1:0]   r_num [NW];
    logic [DW-1:0]   r_rem [NW];
    logic [DW-1:0]   r_den [NW];
    logic [TW-1:0]   r_tag [NW];
    logic [QW-1:0]   r_quo [NW];
    logic            r_ovf [NW];
    logic            r_vld [NW];

    for (genvar k = 0; k < NW; k++) begin : g_st
        localparam int BIT = NW - 1 - k;
        logic [NW-1:0] p_num;
        logic [DW-1:0] p_rem, p_den;
        logic [TW-1:0] p_tag;
        logic [QW-1:0] p_quo;
        logic          p_ovf, p_vld;
        logic [DW:0]   n_sh;
        logic          n_ge;
        if (k == 0) begin : g_head
            always_comb begin
                p_num = i_num;
                p_rem = '0;
                p_den = i_den;
                p_tag = i_tag;
                p_quo = '0;
                p_ovf = 1'b0;
                p_vld = i_valid;
            end
        end else begin : g_tail
            always_comb begin
                p_num = r_num[k-1];
                p_rem = r_rem[k-1];
                p_den = r_den[k-1];
                p_tag = r_tag[k-1];
                p_quo = r_quo[k-1];
                p_ovf = r_ovf[k-1];
                p_vld = r_vld[k-1];
            end
        end
        always_comb begin
            n_sh = {p_rem, p_num[BIT]};
            n_ge = n_sh >= {1'b0, p_den};
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= p_vld;
            end
            if (i_en) begin
                r_num[k] <= p_num;
                r_den[k] <= p_den;
                r_tag[k] <= p_tag;
                r_rem[k] <= n_ge ? DW'(n_sh - {1'b0, p_den}) : DW'(n_sh);
                if (BIT >= QW) begin
                    r_quo[k] <= p_quo;
                    r_ovf[k] <= p_ovf | n_ge;
                end else begin
                    r_quo[k] <= p_quo | (QW'(n_ge) << BIT);
                    r_ovf[k] <= p_ovf;
                end
            end
        end
    end

    assign o_valid = r_vld[NW-1];
    assign o_quo   = (r_ovf[NW-1] || r_quo[NW-1] > QMAX) ? QMAX : r_quo[NW-1];
    assign o_tag   = r_tag[NW-1];
endmodule
`default_nettype wire

// File: sv/softened_gravity_kick_drift_core.sv
// Top level of the softened gravity kick and drift core.
//
//  channel  | dir | payload
//  in_ch    | in  | operation, pos, vel, particle_mass, com, node_mass
//  out_ch   | out | new_pos, new_vel, status
//  cfg      | in  | i_cfg_we, i_cfg_idx, i_cfg_data
//
// One item enters per cycle, back to back, unless the output stalls.
// There are 143 register stages: three offset and square stages, 32 square
// root stages, three multiply stages, 104 divider stages and the output register.
// Reset clears all valid bits and loads the register defaults.
// A stall at the output freezes the whole pipeline; nothing is lost.
`default_nettype none
module softened_gravity_kick_drift_core
    import sgkd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data,
    sgkd_if.sink             in_ch,
    sgkd_if.source           out_ch
);
    localparam int W   = WORD_WIDTH;
    localparam int W2  = 2 * W;
    localparam int SH  = (2 * FRAC_BITS >= GRAV_FRAC) ? 2 * FRAC_BITS - GRAV_FRAC : 0;
    localparam int DSH = (2 * FRAC_BITS <  GRAV_FRAC) ? GRAV_FRAC - 2 * FRAC_BITS : 0;
    localparam int NW  = 3 * W + SH;
    localparam int DW  = 3 * W + DSH + 2;
    localparam int TW  = 2 + 6 * W + 5;

    // Input payload fields.
    logic [1:0]   op_in;
    logic [W-1:0] in_pos [3];
    logic [W-1:0] in_vel [3];
    logic [W-1:0] in_com [3];
    logic [W-1:0] in_m, in_nm;
    always_comb begin
        op_in     = in_ch.data.operation;
        in_pos[0] = W'(in_ch.data.pos_x);
        in_pos[1] = W'(in_ch.data.pos_y);
        in_pos[2] = W'(in_ch.data.pos_z);
        in_vel[0] = W'(in_ch.data.vel_x);
        in_vel[1] = W'(in_ch.data.vel_y);
        in_vel[2] = W'(in_ch.data.vel_z);
        in_com[0] = W'(in_ch.data.com_x);
        in_com[1] = W'(in_ch.data.com_y);
        in_com[2] = W'(in_ch.data.com_z);
        in_m      = W'(in_ch.data.particle_mass);
        in_nm     = W'(in_ch.data.node_mass);
    end

    logic [W-1:0]  r_soft, r_grav;
    logic [15:0]   r_fps;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_soft <= W'(65536);
            r_grav <= W'(16777216);
            r_fps  <= 16'd60;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SOFTENING: r_soft <= W'(i_cfg_data);
                CFG_GRAVITY:   r_grav <= W'(i_cfg_data);
                CFG_FPS:       r_fps  <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Output skid: pipeline advances when the output register is free or its item is taken.
    logic r_ovld;
    logic en;
    assign en = !r_ovld || out_ch.ready;
    assign in_ch.ready = en;

    // Stage 1: offsets.
    logic         r1_v;
    logic [1:0]   r1_op;
    logic [W-1:0] r1_pos [3], r1_vel [3], r1_d [3];
    logic         r1_dsat;
    logic         r1_mz;
    logic [W-1:0] r1_nm;
    logic [W:0]   n1_diff [3];
    logic [W-1:0] n1_d [3];
    logic [2:0]   n1_s;
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            n1_diff[a] = {in_pos[a][W-1], in_pos[a]} - {in_com[a][W-1], in_com[a]};
            if (n1_diff[a][W] != n1_diff[a][W-1]) begin
                n1_d[a] = n1_diff[a][W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
                n1_s[a] = 1'b1;
            end else begin
                n1_d[a] = n1_diff[a][W-1:0];
                n1_s[a] = 1'b0;
            end
        end
        if (op_in == OP_KICK_2D) begin
            n1_d[2] = '0;
            n1_s[2] = 1'b0;
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_v <= 1'b0;
        else if (en) r1_v <= in_ch.valid;
        if (en) begin
            r1_op   <= op_in;
            r1_pos  <= in_pos;
            r1_vel  <= in_vel;
            r1_d    <= n1_d;
            r1_dsat <= |n1_s;
            r1_mz   <= in_m == '0;
            r1_nm   <= in_nm;
        end
    end

    // Stage 2: squares and magnitudes; G*M product.
    logic         r2_v;
    logic [1:0]   r2_op;
    logic [W-1:0] r2_pos [3], r2_vel [3];
    logic [2:0]   r2_neg;
    logic [W-1:0] r2_mag [3];
    logic [W2-1:0] r2_sq [3];
    logic [W2-1:0] r2_gm;
    logic         r2_dsat, r2_mz;
    logic [W-1:0] n2_mag [3];
    always_comb begin
        for (int a = 0; a < 3; a++)
            n2_mag[a] = r1_d[a][W-1] ? W'(-r1_d[a]) : r1_d[a];
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_v <= 1'b0;
        else if (en) r2_v <= r1_v;
        if (en) begin
            r2_op   <= r1_op;
            r2_pos  <= r1_pos;
            r2_vel  <= r1_vel;
            for (int a = 0; a < 3; a++) begin
                r2_neg[a] <= r1_d[a][W-1];
                r2_mag[a] <= n2_mag[a];
                r2_sq[a]  <= W2'(n2_mag[a]) * W2'(n2_mag[a]);
            end
            r2_gm   <= W2'(r_grav) * W2'(r1_nm);
            r2_dsat <= r1_dsat;
            r2_mz   <= r1_mz;
        end
    end

    // Stage 3: sum of squares (wraps at 2W).
    logic         r3_v;
    logic [1:0]   r3_op;
    logic [W-1:0] r3_pos [3], r3_vel [3];
    logic [2:0]   r3_neg;
    logic [W-1:0] r3_mag [3];
    logic [W2-1:0] r3_r2, r3_gm;
    logic         r3_dsat, r3_mz;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_v <= 1'b0;
        else if (en) r3_v <= r2_v;
        if (en) begin
            r3_op   <= r2_op;
            r3_pos  <= r2_pos;
            r3_vel  <= r2_vel;
            r3_neg  <= r2_neg;
            r3_mag  <= r2_mag;
            r3_r2   <= r2_sq[0] + r2_sq[1] + r2_sq[2];
            r3_gm   <= r2_gm;
            r3_dsat <= r2_dsat;
            r3_mz   <= r2_mz;
        end
    end

    // Square root: one result bit per stage over W stages.
    typedef struct packed {
        logic [1:0]   op;
        logic [W-1:0] p0, p1, p2, v0, v1, v2, m0, m1, m2;
        logic [2:0]   neg;
        logic [W2-1:0] gm;
        logic         dsat, mz;
    } t_side;
    t_side         r_sq_sd  [W];
    logic [W2-1:0] r_sq_x   [W];
    logic [W2-1:0] r_sq_res [W];
    logic          r_sq_v   [W];
    for (genvar k = 0; k < W; k++) begin : g_sq
        localparam int BP = W2 - 2 - 2 * k;
        t_side         p_sd;
        logic [W2-1:0] p_x, p_res;
        logic          p_v;
        logic [W2-1:0] n_bit, n_t;
        logic          n_ge;
        if (k == 0) begin : g_head
            always_comb begin
                p_v   = r3_v;
                p_x   = r3_r2;
                p_res = '0;
                p_sd  = {r3_op, r3_pos[0], r3_pos[1], r3_pos[2],
                         r3_vel[0], r3_vel[1], r3_vel[2],
                         r3_mag[0], r3_mag[1], r3_mag[2],
                         r3_neg, r3_gm, r3_dsat, r3_mz};
            end
        end else begin : g_tail
            always_comb begin
                p_v   = r_sq_v[k-1];
                p_x   = r_sq_x[k-1];
                p_res = r_sq_res[k-1];
                p_sd  = r_sq_sd[k-1];
            end
        end
        always_comb begin
            n_bit = W2'(1) << BP;
            n_t   = p_res + n_bit;
            n_ge  = p_x >= n_t;
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_sq_v[k] <= 1'b0;
            else if (en) r_sq_v[k] <= p_v;
            if (en) begin
                r_sq_sd[k]  <= p_sd;
                r_sq_x[k]   <= n_ge ? p_x - n_t : p_x;
                r_sq_res[k] <= n_ge ? (p_res >> 1) + n_bit : p_res >> 1;
            end
        end
    end

    // Stage after sqrt: r*r and q.
    logic          r4_v;
    t_side         r4_sd;
    logic [W-1:0]  r4_r, r4_q;
    logic [W2-1:0] r4_rr;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r4_v <= 1'b0;
        else if (en) r4_v <= r_sq_v[W-1];
        if (en) begin
            r4_sd <= r_sq_sd[W-1];
            r4_r  <= W'(r_sq_res[W-1]);
            r4_q  <= (W'(r_sq_res[W-1]) <= r_soft) ? r_soft : W'(r_sq_res[W-1]);
            r4_rr <= W2'(r_sq_res[W-1][W-1:0]) * W2'(r_sq_res[W-1][W-1:0]);
        end
    end

    // Partial products of r^2*q and G*M*|d|, with r^2 and G*M split into word halves.
    logic          r5_v;
    t_side         r5_sd;
    logic          r5_rz;
    logic [W2-1:0] r5_den_lo, r5_den_hi;
    logic [W2-1:0] r5_num_lo [3], r5_num_hi [3];
    logic [W-1:0]  n5_mag [3];
    always_comb begin
        n5_mag[0] = r4_sd.m0;
        n5_mag[1] = r4_sd.m1;
        n5_mag[2] = r4_sd.m2;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r5_v <= 1'b0;
        else if (en) r5_v <= r4_v;
        if (en) begin
            r5_sd     <= r4_sd;
            r5_rz     <= r4_r == '0;
            r5_den_lo <= W2'(r4_rr[W-1:0]) * W2'(r4_q);
            r5_den_hi <= W2'(r4_rr[W2-1:W]) * W2'(r4_q);
            for (int a = 0; a < 3; a++) begin
                r5_num_lo[a] <= W2'(r4_sd.gm[W-1:0]) * W2'(n5_mag[a]);
                r5_num_hi[a] <= W2'(r4_sd.gm[W2-1:W]) * W2'(n5_mag[a]);
            end
        end
    end

    // Denominator r^2*q, and the three numerators G*M*|d|.
    logic           r6_v;
    t_side          r6_sd;
    logic           r6_rz;
    logic [3*W-1:0] r6_den;
    logic [3*W-1:0] r6_num [3];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r6_v <= 1'b0;
        else if (en) r6_v <= r5_v;
        if (en) begin
            r6_sd  <= r5_sd;
            r6_rz  <= r5_rz;
            r6_den <= ((3*W)'(r5_den_hi) << W) + (3*W)'(r5_den_lo);
            for (int a = 0; a < 3; a++)
                r6_num[a] <= ((3*W)'(r5_num_hi[a]) << W) + (3*W)'(r5_num_lo[a]);
        end
    end

    // Three parallel dividers share the side data through the first one's tag.
    logic [NW-1:0] dv_num [3];
    logic [DW-1:0] dv_den;
    logic [TW-1:0] dv_tag_in, dv_tag_out;
    logic [2:0]    dv_v;
    logic [W:0]    dv_q [3];
    logic [1:0]    dv_tag_unused;
    always_comb begin
        dv_den = (DW'(r6_den) << DSH) | DW'(r6_rz | r6_sd.mz);
        for (int a = 0; a < 3; a++)
            dv_num[a] = NW'(r6_num[a]) << SH;
        dv_tag_in = {r6_sd.op, r6_sd.p0, r6_sd.p1, r6_sd.p2,
                     r6_sd.v0, r6_sd.v1, r6_sd.v2, r6_sd.neg[0], r6_sd.neg[1],
                     r6_sd.neg[2], r6_sd.dsat, r6_sd.mz | r6_rz};
    end
    for (genvar a = 0; a < 3; a++) begin : g_dv
        if (a == 0) begin : g_main
            sgkd_div #(.NW(NW), .DW(DW), .QW(W+1), .TW(TW)) u_div (
                .i_clk, .i_rst_n, .i_en(en), .i_valid(r6_v),
                .i_num(dv_num[a]), .i_den(dv_den),
                .i_tag(dv_tag_in), .o_valid(dv_v[a]), .o_quo(dv_q[a]),
                .o_tag(dv_tag_out));
        end else begin : g_aux
            sgkd_div #(.NW(NW), .DW(DW), .QW(W+1), .TW(1)) u_div (
                .i_clk, .i_rst_n, .i_en(en), .i_valid(r6_v),
                .i_num(dv_num[a]), .i_den(dv_den),
                .i_tag(1'b0), .o_valid(dv_v[a]), .o_quo(dv_q[a]),
                .o_tag(dv_tag_unused[a-1]));
        end
    end

    // Drift divides |velocity| by the frame rate over the same number of
    // stages, so its quotients line up with the kick results.
    logic [W-1:0]  n6_vel [3];
    logic [NW-1:0] dr_num [3];
    logic [15:0]   dr_den;
    logic [2:0]    dr_v;
    logic [2:0]    dr_neg;
    logic [W:0]    dr_q [3];
    always_comb begin
        n6_vel[0] = r6_sd.v0;
        n6_vel[1] = r6_sd.v1;
        n6_vel[2] = r6_sd.v2;
        dr_den = (r_fps == '0) ? 16'd1 : r_fps;
        for (int a = 0; a < 3; a++)
            dr_num[a] = NW'(n6_vel[a][W-1] ? W'(-n6_vel[a]) : n6_vel[a]);
    end
    for (genvar a = 0; a < 3; a++) begin : g_dr
        sgkd_div #(.NW(NW), .DW(16), .QW(W+1), .TW(1)) u_div (
            .i_clk, .i_rst_n, .i_en(en), .i_valid(r6_v),
            .i_num(dr_num[a]), .i_den(dr_den),
            .i_tag(n6_vel[a][W-1]), .o_valid(dr_v[a]), .o_quo(dr_q[a]),
            .o_tag(dr_neg[a]));
    end

    // Final stage: unpack, apply kick, drift, or pass, and saturate.
    logic [1:0]   f_op;
    logic [W-1:0] f_pos [3], f_vel [3];
    logic [2:0]   f_neg;
    logic         f_dsat, f_skip;
    logic         f_v;
    logic [W-1:0] dq [3];
    always_comb begin
        {f_op, f_pos[0], f_pos[1], f_pos[2], f_vel[0], f_vel[1], f_vel[2],
         f_neg[0], f_neg[1], f_neg[2], f_dsat, f_skip} = dv_tag_out;
        f_v = &{dv_v, dr_v};
        for (int a = 0; a < 3; a++)
            dq[a] = dr_neg[a] ? W'(-dr_q[a]) : W'(dr_q[a]);
    end

    logic [W+1:0] n_acc [3];
    logic [W-1:0] n_np [3], n_nv [3];
    logic         n_sat;
    t_status      n_st;
    always_comb begin
        n_sat = 1'b0;
        n_np  = f_pos;
        n_nv  = f_vel;
        n_st  = ST_OK;
        for (int a = 0; a < 3; a++) n_acc[a] = '0;
        unique case (f_op)
            OP_KICK_3D, OP_KICK_2D: begin
                if (f_skip) begin
                    n_st = ST_SKIP;
                end else begin
                    n_sat = f_dsat;
                    for (int a = 0; a < 3; a++) begin
                        if (a < 2 || f_op == OP_KICK_3D) begin
                            n_acc[a] = f_neg[a] ?
                                {{2{f_vel[a][W-1]}}, f_vel[a]} + {1'b0, dv_q[a]} :
                                {{2{f_vel[a][W-1]}}, f_vel[a]} - {1'b0, dv_q[a]};
                            if (n_acc[a][W+1] && !(&n_acc[a][W:W-1])) begin
                                n_nv[a] = {1'b1, {(W-1){1'b0}}};
                                n_sat   = 1'b1;
                            end else if (!n_acc[a][W+1] && (|n_acc[a][W:W-1])) begin
                                n_nv[a] = {1'b0, {(W-1){1'b1}}};
                                n_sat   = 1'b1;
                            end else begin
                                n_nv[a] = n_acc[a][W-1:0];
                            end
                        end
                    end
                end
            end
            OP_DRIFT: begin
                for (int a = 0; a < 3; a++) begin
                    n_acc[a] = {{2{f_pos[a][W-1]}}, f_pos[a]} + {{2{dq[a][W-1]}}, dq[a]};
                    if (n_acc[a][W+1] != n_acc[a][W-1]) begin
                        n_np[a] = n_acc[a][W+1] ? {1'b1, {(W-1){1'b0}}}
                                                : {1'b0, {(W-1){1'b1}}};
                        n_sat   = 1'b1;
                    end else begin
                        n_np[a] = n_acc[a][W-1:0];
                    end
                end
            end
            default: ;
        endcase
        if (n_sat) n_st = ST_SAT;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ovld <= 1'b0;
        else if (en) r_ovld <= f_v;
        if (en) begin
            out_ch.data.new_pos_x <= 32'(n_np[0]);
            out_ch.data.new_pos_y <= 32'(n_np[1]);
            out_ch.data.new_pos_z <= 32'(n_np[2]);
            out_ch.data.new_vel_x <= 32'(n_nv[0]);
            out_ch.data.new_vel_y <= 32'(n_nv[1]);
            out_ch.data.new_vel_z <= 32'(n_nv[2]);
            out_ch.data.status    <= n_st;
        end
    end
    assign out_ch.valid = r_ovld;
endmodule
`default_nettype wire
